[rtl/prod_pkg.sv]
// prod_pkg: shared types, widths and constants for the probe ring
// displacement unit; used by every module under rtl
package prod_pkg;

    // sample and field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int PROBE_COUNT  = 8;
    localparam int TIME_W       = 32;
    localparam int OUT_W        = 24;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // datapath widths and shifts, most widths derived from the sample width
    localparam int X0_W      = SAMPLE_WIDTH + 3;
    localparam int DIFF_W    = SAMPLE_WIDTH + 1;
    localparam int SUM4_W    = SAMPLE_WIDTH + 3;
    localparam int RE_W      = SAMPLE_WIDTH + 20;
    localparam int NUM_W     = SAMPLE_WIDTH + 36;
    localparam int NMAG_W    = NUM_W - 1;
    localparam int SPLIT_W   = 25;
    localparam int PLO_W     = CFG_W + SPLIT_W;
    localparam int PHI_W     = CFG_W + NMAG_W - SPLIT_W;
    localparam int PROD_W    = SAMPLE_WIDTH + 52;
    localparam int FRAC_SH   = 31;
    localparam int HALF_SH   = 30;
    localparam int T_W       = PROD_W - FRAC_SH;
    localparam int DMAG_W    = SAMPLE_WIDTH + 3;
    localparam int QUOT_W    = 25;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // sqrt(2)/2 in Q16
    localparam logic signed [17:0] HALF_SQRT2_Q16 = 18'sd46341;

    // saturation limits
    localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(8388607);
    localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(8388608);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RADIUS_RST = 16'd2581;
    localparam logic [CFG_W-1:0] COS_RST    = 16'd30274;
    localparam logic [CFG_W-1:0] SIN_RST    = 16'd12540;

    typedef struct packed {
        logic [TIME_W-1:0]              time_stamp;
        logic signed [SAMPLE_WIDTH-1:0] probe_a0;
        logic signed [SAMPLE_WIDTH-1:0] probe_a45;
        logic signed [SAMPLE_WIDTH-1:0] probe_a90;
        logic signed [SAMPLE_WIDTH-1:0] probe_a135;
        logic signed [SAMPLE_WIDTH-1:0] probe_a180;
        logic signed [SAMPLE_WIDTH-1:0] probe_a225;
        logic signed [SAMPLE_WIDTH-1:0] probe_a270;
        logic signed [SAMPLE_WIDTH-1:0] probe_a315;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0]       time_out;
        logic signed [OUT_W-1:0] x_disp;
        logic signed [OUT_W-1:0] y_disp;
        logic                    dc_zero;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]        radius;
        logic signed [CFG_W-1:0] cos_q15;
        logic signed [CFG_W-1:0] sin_q15;
    } t_cfg;

    // one row ready for division
    typedef struct packed {
        logic [TIME_W-1:0] time_stamp;
        logic [T_W-1:0]    tx;
        logic [T_W-1:0]    ty;
        logic [DMAG_W-1:0] dmag;
        logic              negx;
        logic              negy;
        logic              dc_zero;
    } t_work;

endpackage

[rtl/probe_ring_offaxis_displacement_unit.sv]
// probe_ring_offaxis_displacement_unit: top level, config registers, front,
// queue and divider back end; depends on prod_pkg and the prod_* modules
// throughput: one row per cycle while the output is not stalled
// path: an accepted row passes the five front stages, the queue, the
//   divider load stage, the 25 quotient stages and the output register
// reset: synchronous active low, clears valids and queue, loads config defaults
module probe_ring_offaxis_displacement_unit import prod_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    logic  push, q_full, q_empty, pop;
    t_work front_work, q_work;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius  <= RADIUS_RST;
            r_cfg.cos_q15 <= COS_RST;
            r_cfg.sin_q15 <= SIN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_RADIUS) begin
                r_cfg.radius <= i_cfg_data;
            end else if (i_cfg_idx == CFG_COS) begin
                r_cfg.cos_q15 <= i_cfg_data;
            end else if (i_cfg_idx == CFG_SIN) begin
                r_cfg.sin_q15 <= i_cfg_data;
            end
        end
    end

    prod_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .i_q_full (q_full),
        .o_work   (front_work)
    );

    prod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_work  (q_work)
    );

    prod_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_work  (q_work),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

[rtl/prod_front.sv]
// prod_front: five stage front end, dft bins, rotation and radius scaling
// depends on prod_pkg
module prod_front import prod_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_push,
    input  logic     i_q_full,
    output t_work    o_work
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [TIME_W-1:0]        r_time1, r_time2, r_time3, r_time4;
    logic signed [X0_W-1:0]   r_x0_1;
    logic signed [DIFF_W-1:0] r_d04, r_d26;
    logic signed [SUM4_W-1:0] r_s1, r_s2;
    logic [DMAG_W-1:0]        r_dmag2, r_dmag3, r_dmag4;
    logic                     r_x0neg2, r_x0neg3;
    logic                     r_dcz2, r_dcz3, r_dcz4;
    logic signed [RE_W-1:0]   r_re, r_im;
    logic signed [NUM_W-1:0]  r_nx, r_ny;
    logic                     r_negx4, r_negy4;
    logic [PLO_W-1:0]         r_plox, r_ploy;
    logic [PHI_W-1:0]         r_phix, r_phiy;
    t_work                    r_work;

    logic signed [X0_W-1:0]   n_x0;
    logic signed [RE_W-1:0]   n_re, n_im;
    logic signed [NUM_W-1:0]  n_nx, n_ny;
    logic [NMAG_W-1:0]        magx, magy;
    logic [PROD_W-1:0]        sumx, sumy;

    // the pipe moves unless the last stage holds an item the queue cannot take
    assign en      = !r_v5 || !i_q_full;
    assign o_stall = !en;
    assign o_push  = r_v5 && !i_q_full;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: dc sum and opposite-probe differences
    always_comb begin
        n_x0 = X0_W'(i_item.probe_a0) + X0_W'(i_item.probe_a45)
             + X0_W'(i_item.probe_a90) + X0_W'(i_item.probe_a135)
             + X0_W'(i_item.probe_a180) + X0_W'(i_item.probe_a225)
             + X0_W'(i_item.probe_a270) + X0_W'(i_item.probe_a315);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_time1 <= i_item.time_stamp;
            r_x0_1  <= n_x0;
            r_d04   <= DIFF_W'(i_item.probe_a0) - DIFF_W'(i_item.probe_a180);
            r_d26   <= DIFF_W'(i_item.probe_a90) - DIFF_W'(i_item.probe_a270);
            r_s1    <= SUM4_W'(i_item.probe_a45) - SUM4_W'(i_item.probe_a135)
                     - SUM4_W'(i_item.probe_a225) + SUM4_W'(i_item.probe_a315);
            r_s2    <= SUM4_W'(i_item.probe_a45) + SUM4_W'(i_item.probe_a135)
                     - SUM4_W'(i_item.probe_a225) - SUM4_W'(i_item.probe_a315);
        end
    end

    // stage 2: first harmonic bin in Q16 sample units, dc magnitude, flags
    always_comb begin
        n_re = (RE_W'(r_d04) <<< 16) + RE_W'(r_s1) * RE_W'(HALF_SQRT2_Q16);
        n_im = -((RE_W'(r_d26) <<< 16) + RE_W'(r_s2) * RE_W'(HALF_SQRT2_Q16));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_time2  <= r_time1;
            r_re     <= n_re;
            r_im     <= n_im;
            r_x0neg2 <= r_x0_1[X0_W-1];
            r_dcz2   <= (r_x0_1 == '0);
            r_dmag2  <= r_x0_1[X0_W-1] ? DMAG_W'(-r_x0_1) : DMAG_W'(r_x0_1);
        end
    end

    // stage 3: rotate by the probe offset
    always_comb begin
        n_nx = NUM_W'(r_re) * NUM_W'(i_cfg.cos_q15) + NUM_W'(r_im) * NUM_W'(i_cfg.sin_q15);
        n_ny = NUM_W'(r_re) * NUM_W'(i_cfg.sin_q15) - NUM_W'(r_im) * NUM_W'(i_cfg.cos_q15);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_time3  <= r_time2;
            r_nx     <= n_nx;
            r_ny     <= n_ny;
            r_x0neg3 <= r_x0neg2;
            r_dcz3   <= r_dcz2;
            r_dmag3  <= r_dmag2;
        end
    end

    // stage 4: magnitudes times radius, split in two partial products
    always_comb begin
        magx = r_nx[NUM_W-1] ? NMAG_W'(-r_nx) : NMAG_W'(r_nx);
        magy = r_ny[NUM_W-1] ? NMAG_W'(-r_ny) : NMAG_W'(r_ny);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_time4 <= r_time3;
            r_negx4 <= r_nx[NUM_W-1] ^ r_x0neg3;
            r_negy4 <= r_ny[NUM_W-1] ^ r_x0neg3;
            r_dcz4  <= r_dcz3;
            r_dmag4 <= r_dmag3;
            r_plox  <= PLO_W'(i_cfg.radius) * PLO_W'(magx[SPLIT_W-1:0]);
            r_ploy  <= PLO_W'(i_cfg.radius) * PLO_W'(magy[SPLIT_W-1:0]);
            r_phix  <= PHI_W'(i_cfg.radius) * PHI_W'(magx[NMAG_W-1:SPLIT_W]);
            r_phiy  <= PHI_W'(i_cfg.radius) * PHI_W'(magy[NMAG_W-1:SPLIT_W]);
        end
    end

    // stage 5: join partial products, add rounding half, drop Q31 fraction
    always_comb begin
        sumx = (PROD_W'(r_phix) << SPLIT_W) + PROD_W'(r_plox) + (PROD_W'(r_dmag4) << HALF_SH);
        sumy = (PROD_W'(r_phiy) << SPLIT_W) + PROD_W'(r_ploy) + (PROD_W'(r_dmag4) << HALF_SH);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_work.time_stamp <= r_time4;
            r_work.tx         <= sumx[PROD_W-1:FRAC_SH];
            r_work.ty         <= sumy[PROD_W-1:FRAC_SH];
            r_work.dmag       <= r_dmag4;
            r_work.negx       <= r_negx4;
            r_work.negy       <= r_negy4;
            r_work.dc_zero    <= r_dcz4;
        end
    end

endmodule

[rtl/prod_queue.sv]
// prod_queue: small fifo of rows between front and back
// depends on prod_pkg
module prod_queue import prod_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_work
);

    t_work              r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule

[rtl/prod_back.sv]
// prod_back: pipelined restoring divider, one quotient bit per stage,
// for x and y lanes, with saturation into the output register; uses prod_pkg
module prod_back import prod_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_work     i_work,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int HI_W = T_W - QUOT_W;

    logic en;
    logic r_v [0:QUOT_W];
    logic r_ov;

    logic [TIME_W-1:0] r_time [0:QUOT_W];
    logic              r_dcz  [0:QUOT_W];
    logic [DMAG_W-1:0] r_dmag [0:QUOT_W];
    logic [DMAG_W-1:0] r_rem  [0:1][0:QUOT_W];
    logic [QUOT_W-1:0] r_low  [0:1][0:QUOT_W];
    logic [QUOT_W-1:0] r_quo  [0:1][0:QUOT_W];
    logic              r_neg  [0:1][0:QUOT_W];
    logic              r_sat  [0:1][0:QUOT_W];
    t_out_item         r_item;

    logic [T_W-1:0]    t_in  [0:1];
    logic [DMAG_W:0]   trial [0:1][1:QUOT_W];
    logic              ge    [0:1][1:QUOT_W];
    logic [QUOT_W-1:0] qlim  [0:1];
    logic [QUOT_W-1:0] qneg  [0:1];
    logic [OUT_W-1:0]  res   [0:1];

    assign en      = !r_ov || !i_stall;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_item  = r_item;

    assign t_in[0] = i_work.tx;
    assign t_in[1] = i_work.ty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUOT_W; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
            for (int k = 1; k <= QUOT_W; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[QUOT_W];
        end
    end

    // one trial subtraction per stage and lane
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 1; k <= QUOT_W; k++) begin
                trial[l][k] = {r_rem[l][k-1], r_low[l][k-1][QUOT_W-1]};
                ge[l][k]    = (trial[l][k] >= {1'b0, r_dmag[k-1]});
            end
        end
    end

    // load from the queue, then shift one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_time[0] <= i_work.time_stamp;
            r_dcz[0]  <= i_work.dc_zero;
            r_dmag[0] <= i_work.dmag;
            r_neg[0][0] <= i_work.negx;
            r_neg[1][0] <= i_work.negy;
            for (int l = 0; l < 2; l++) begin
                // quotient of 2^25 or more cannot fit the output
                r_sat[l][0] <= (DMAG_W'(t_in[l][T_W-1 -: HI_W]) >= i_work.dmag);
                r_rem[l][0] <= DMAG_W'(t_in[l][T_W-1 -: HI_W]);
                r_low[l][0] <= t_in[l][QUOT_W-1:0];
                r_quo[l][0] <= '0;
            end
            for (int k = 1; k <= QUOT_W; k++) begin
                r_time[k] <= r_time[k-1];
                r_dcz[k]  <= r_dcz[k-1];
                r_dmag[k] <= r_dmag[k-1];
                for (int l = 0; l < 2; l++) begin
                    r_neg[l][k] <= r_neg[l][k-1];
                    r_sat[l][k] <= r_sat[l][k-1];
                    r_low[l][k] <= r_low[l][k-1] << 1;
                    r_quo[l][k] <= {r_quo[l][k-1][QUOT_W-2:0], ge[l][k]};
                    r_rem[l][k] <= ge[l][k] ? DMAG_W'(trial[l][k] - {1'b0, r_dmag[k-1]})
                                            : DMAG_W'(trial[l][k]);
                end
            end
        end
    end

    // saturate and apply the sign
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[l][QUOT_W]) begin
                qlim[l] = (r_sat[l][QUOT_W] || r_quo[l][QUOT_W] > NEG_LIMIT)
                        ? NEG_LIMIT : r_quo[l][QUOT_W];
            end else begin
                qlim[l] = (r_sat[l][QUOT_W] || r_quo[l][QUOT_W] > POS_LIMIT)
                        ? POS_LIMIT : r_quo[l][QUOT_W];
            end
            qneg[l] = '0 - qlim[l];
            res[l]  = r_neg[l][QUOT_W] ? qneg[l][OUT_W-1:0] : qlim[l][OUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item.time_out <= r_time[QUOT_W];
            r_item.dc_zero  <= r_dcz[QUOT_W];
            r_item.x_disp   <= r_dcz[QUOT_W] ? '0 : res[0];
            r_item.y_disp   <= r_dcz[QUOT_W] ? '0 : res[1];
        end
    end

endmodule

[tb/tb.sv]
// tb: self-checking bench for probe_ring_offaxis_displacement_unit
// drives probe rows and register writes, predicts items save fixed directed ones
// depends on prod_pkg and the rtl of the unit
module tb;
    import prod_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM     = 1400;

    typedef struct {
        t_in_item  row;
        logic      fixed;
        t_out_item want;
    } t_probe_case;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_item             i_item;
    logic                 o_valid;
    logic                 i_stall;
    t_out_item            o_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    // typed expectation travelling with the row being offered
    logic      row_fixed;
    t_out_item row_want;

    // bench copy of the registers
    logic [CFG_W-1:0]        radius_now;
    logic signed [CFG_W-1:0] cos_now;
    logic signed [CFG_W-1:0] sin_now;

    t_out_item disp_pending[$];
    int        mismatch_cnt;
    int        rows_sent;
    int        disp_seen;
    int        dc_zero_seen;
    int        sat_seen;
    bit        rx_calm;

    probe_ring_offaxis_displacement_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // rounded, saturated rad*num/(den*2^31) for nonzero den
    function automatic logic [OUT_W-1:0] scale_disp(logic signed [63:0] num,
                                                   logic signed [63:0] den,
                                                   logic [CFG_W-1:0] rad);
        logic [63:0]  nmag;
        logic [63:0]  dmag;
        logic [127:0] quot;
        logic         neg;
        neg  = (num < 0) != (den < 0);
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        quot = (128'(nmag) * 128'(rad) + (128'(dmag) << 30)) / (128'(dmag) << 31);
        if (neg) begin
            if (quot > 128'd8388608) quot = 128'd8388608;
            return -quot[OUT_W-1:0];
        end
        if (quot > 128'd8388607) quot = 128'd8388607;
        return quot[OUT_W-1:0];
    endfunction

    // first-harmonic centroid of one probe row under the current registers
    function automatic t_out_item predict_disp(t_in_item r);
        logic signed [63:0] a[PROBE_COUNT];
        logic signed [63:0] dc, re, im, c, s, nx, ny;
        t_out_item          d;
        a[0] = 64'(r.probe_a0);   a[1] = 64'(r.probe_a45);
        a[2] = 64'(r.probe_a90);  a[3] = 64'(r.probe_a135);
        a[4] = 64'(r.probe_a180); a[5] = 64'(r.probe_a225);
        a[6] = 64'(r.probe_a270); a[7] = 64'(r.probe_a315);
        dc = 0;
        for (int k = 0; k < PROBE_COUNT; k++) dc += a[k];
        re = (a[0] - a[4]) * 65536 + 64'sd46341 * (a[1] - a[3] - a[5] + a[7]);
        im = -((a[2] - a[6]) * 65536 + 64'sd46341 * (a[1] + a[3] - a[5] - a[7]));
        c  = 64'(cos_now);
        s  = 64'(sin_now);
        nx = re * c + im * s;
        ny = re * s - im * c;
        d.time_out = r.time_stamp;
        if (dc == 0) begin
            d.x_disp  = '0;
            d.y_disp  = '0;
            d.dc_zero = 1'b1;
        end else begin
            d.x_disp  = scale_disp(nx, dc, radius_now);
            d.y_disp  = scale_disp(ny, dc, radius_now);
            d.dc_zero = 1'b0;
        end
        return d;
    endfunction

    function automatic t_in_item make_row(logic [31:0] ts,
                                          logic [15:0] p0, logic [15:0] p1,
                                          logic [15:0] p2, logic [15:0] p3,
                                          logic [15:0] p4, logic [15:0] p5,
                                          logic [15:0] p6, logic [15:0] p7);
        return '{ts, p0, p1, p2, p3, p4, p5, p6, p7};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // record accepted rows and check finished items
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_valid && !o_stall) begin
            disp_pending.push_back(row_fixed ? row_want : predict_disp(i_item));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            disp_seen++;
            if (o_item.dc_zero) dc_zero_seen++;
            if (o_item.x_disp == 24'h7fffff || o_item.x_disp == 24'h800000) sat_seen++;
            if (disp_pending.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected item time=%h x=%h y=%h z=%b",
                             o_item.time_out, o_item.x_disp, o_item.y_disp,
                             o_item.dc_zero);
            end else begin
                want = disp_pending.pop_front();
                if (o_item !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: time exp %h got %h | x exp %h got %h | %s%h got %h | %s%b got %b",
                                 want.time_out, o_item.time_out, want.x_disp,
                                 o_item.x_disp, "y exp ", want.y_disp, o_item.y_disp,
                                 "dc_zero exp ", want.dc_zero, o_item.dc_zero);
                end
            end
        end
    end

    // receiver stall: calm stretches and bursty stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
        if (rx_calm) begin
            i_stall <= 1'b0;
        end else if (i_stall) begin
            i_stall <= ($urandom_range(0, 99) < 70);
        end else begin
            i_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    // offer one row and hold it until taken, then maybe leave a gap
    task automatic send_row(t_in_item r, logic fixed, t_out_item want);
        int gap;
        i_item    <= r;
        row_fixed <= fixed;
        row_want  <= want;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        rows_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for the unit to drain, then write all three registers and a stray index
    task automatic write_regs(logic [15:0] rad, logic [15:0] c, logic [15:0] s);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (disp_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RADIUS;
        i_cfg_data <= rad;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COS;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SIN;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= 16'h0000;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radius_now = rad;
        cos_now    = c;
        sin_now    = s;
        @(posedge i_clk);
    endtask

    // random row: some modest values, mostly full range, some zero dc sum
    function automatic t_in_item random_row();
        logic [15:0] p[PROBE_COUNT];
        int          mode;
        int          lim;
        mode = $urandom_range(0, 9);
        lim  = (mode < 4) ? 300 : 32767;
        for (int k = 0; k < PROBE_COUNT; k++)
            p[k] = 16'($signed($urandom_range(0, 2 * lim)) - lim);
        if (mode >= 8) begin
            for (int k = 4; k < PROBE_COUNT; k++) p[k] = -p[k - 4];
            if (p[0] == 16'h8000) p[0] = 16'h0000;
            p[4] = -p[0];
        end else if (mode == 7) begin
            // dc sum near zero with a strong first harmonic
            p[4] = -p[0]; p[6] = -p[2];
            p[5] = -p[1]; p[7] = -p[3] + 16'($urandom_range(0, 4));
        end
        return make_row($urandom, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    endfunction

    t_probe_case probe_cases[$];

    // main sequence
    initial begin
        t_probe_case pc;
        t_out_item   none;
        logic [15:0] rv, cv, sv;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_item       = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_RADIUS;
        i_cfg_data   = '0;
        row_fixed    = 1'b0;
        row_want     = '0;
        rx_calm      = 1'b0;
        radius_now   = RADIUS_RST;
        cos_now      = COS_RST;
        sin_now      = SIN_RST;
        mismatch_cnt = 0;
        rows_sent    = 0;
        disp_seen    = 0;
        dc_zero_seen = 0;
        sat_seen     = 0;
        none         = '0;

        // directed rows under reset registers
        pc = '{make_row(32'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0),
               1'b1, '{32'h0, 24'h0, 24'h0, 1'b1}};
        probe_cases.push_back(pc);
        pc = '{make_row(32'hffffffff, 16'd100, 16'd0, 16'd0, 16'd0,
                        16'd0, 16'd0, 16'd0, 16'd0), 1'b1,
               '{32'hffffffff, 24'd2385, 24'd988, 1'b0}};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h1, 16'sd32767, -16'sd32766, 16'd0, 16'd0,
                        16'd0, 16'd0, 16'd0, 16'd0), 1'b1,
               '{32'h1, 24'h7fffff, 24'h800000, 1'b0}};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h2, 16'sd32767, 16'd0, 16'd0, 16'd0,
                        -16'sd32767, 16'd0, 16'd0, 16'd0), 1'b1,
               '{32'h2, 24'h0, 24'h0, 1'b1}};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h3, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                        16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0, none};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h4, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, none};
        probe_cases.push_back(pc);
        pc = '{make_row(32'haaaaaaaa, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                        16'h7fff, 16'h8000, 16'h7fff, 16'h7fff), 1'b0, none};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h55555555, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h8000, 16'h7fff, 16'h8000, 16'h8000), 1'b0, none};
        probe_cases.push_back(pc);
        pc = '{make_row(32'h5, 16'hffff, 16'd0, 16'd0, 16'd0,
                        16'd0, 16'd0, 16'd0, 16'd0), 1'b0, none};
        probe_cases.push_back(pc);
        // single probe at each angle
        for (int k = 0; k < PROBE_COUNT; k++) begin
            logic [15:0] p[PROBE_COUNT];
            for (int j = 0; j < PROBE_COUNT; j++) p[j] = 16'd0;
            p[k] = (k % 2) ? 16'h8000 : 16'h7fff;
            pc = '{make_row(32'h100 + k, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]),
                   1'b0, none};
            probe_cases.push_back(pc);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_cases[i]) send_row(probe_cases[i].row, probe_cases[i].fixed,
                                          probe_cases[i].want);

        // register settings, extremes first, then random ones
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin rv = 16'hffff; cv = 16'h8000; sv = 16'h7fff; end
                1: begin rv = 16'h0000; cv = 16'h7fff; sv = 16'h8000; end
                2: begin rv = 16'h0001; cv = 16'h7fff; sv = 16'h0000; end
                3: begin rv = 16'hffff; cv = 16'h0000; sv = 16'h8000; end
                default: begin
                    rv = 16'($urandom); cv = 16'($urandom); sv = 16'($urandom);
                end
            endcase
            write_regs(rv, cv, sv);
            for (int n = 0; n < N_RANDOM / 8; n++) send_row(random_row(), 1'b0, none);
        end
        write_regs(RADIUS_RST, COS_RST, SIN_RST);
        for (int n = 0; n < N_RANDOM / 8; n++) send_row(random_row(), 1'b0, none);
        i_valid <= 1'b0;

        // drain
        while (disp_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d rows over 9 register settings, %0d items checked",
                 rows_sent, disp_seen);
        $display("zero dc sum items %0d, saturated x items %0d, mismatches %0d",
                 dc_zero_seen, sat_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && disp_pending.size() == 0) begin
            $display("** probe_ring_offaxis_displacement_unit: PASSED **");
        end else begin
            $display("** probe_ring_offaxis_displacement_unit: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("timeout with %0d items outstanding", disp_pending.size());
        $display("** probe_ring_offaxis_displacement_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/prod_pkg.sv
rtl/prod_front.sv
rtl/prod_queue.sv
rtl/prod_back.sv
rtl/probe_ring_offaxis_displacement_unit.sv
tb/tb.sv
